FILE: rtl/pwc_pkg.sv
// Shared types and constants for the page-walk cache tag store.
`default_nettype none

package pwc_pkg;

  // Defaults of the top-level parameters.
  localparam int SETS_DEFAULT     = 64;
  localparam int MAX_WAYS_DEFAULT = 8;
  localparam int KEY_BITS_DEFAULT = 48;

  // Fixed port widths.
  localparam int KEY_IN_W = 48;
  localparam int SET_IN_W = 6;
  localparam int FUNC_W   = 2;
  localparam int CFG_W    = 4;

  // Width used to compare way counts against the ways register.
  localparam int CMP_W = 7;

  // Reset value of the ways register.
  localparam logic [CFG_W-1:0] WAYS_RESET = 4'd8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACCESS = 2'd0,
    FUNC_FILL   = 2'd1,
    FUNC_FLUSH  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // Write controls from the update logic to the row store.
  typedef struct packed {
    logic write;
    logic flush;
  } store_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/pwc_row_store.sv
// Set row memory with per-row valid flags and write-to-read forwarding.
`default_nettype none

module pwc_row_store
  import pwc_pkg::*;
#(
  parameter int SETS     = SETS_DEFAULT,
  parameter int MAX_WAYS = MAX_WAYS_DEFAULT,
  parameter int KEY_BITS = KEY_BITS_DEFAULT,
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rd_en,
  input  wire logic [SET_W-1:0]             rd_set,
  input  wire store_ctrl_t                  wr_ctrl,
  input  wire logic [SET_W-1:0]             wr_set,
  input  wire logic [MAX_WAYS-1:0]          wr_valid,
  input  wire logic [MAX_WAYS*RANK_W-1:0]   wr_ranks,
  input  wire logic [MAX_WAYS*KEY_BITS-1:0] wr_tags,
  output logic      [MAX_WAYS-1:0]          cur_valid,
  output logic      [MAX_WAYS*RANK_W-1:0]   cur_ranks,
  output logic      [MAX_WAYS*KEY_BITS-1:0] cur_tags
);

  localparam int ROW_W = MAX_WAYS * (KEY_BITS + RANK_W + 1);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_q;
  logic [ROW_W-1:0] byp_q;
  logic             byp_sel;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] row_sel;
  logic [SETS-1:0]  row_valid;
  logic             row_live;

  assign wr_row = {wr_tags, wr_ranks, wr_valid};

  always_ff @(posedge clk) begin
    if (wr_ctrl.write) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_set];
      byp_q <= wr_row;
    end
  end

  // The memory returns old data when the row is written in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_sel <= 1'b0;
    end else begin
      byp_sel <= rd_en && wr_ctrl.write && (rd_set == wr_set);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_ctrl.flush) begin
      row_valid <= '0;
    end else if (wr_ctrl.write) begin
      row_valid[wr_set] <= 1'b1;
    end
  end

  assign row_sel  = byp_sel ? byp_q : rd_q;
  assign row_live = row_valid[wr_set];

  // A row never written since reset or flush reads as empty.
  always_comb begin
    if (row_live) begin
      cur_valid = row_sel[MAX_WAYS-1:0];
      cur_ranks = row_sel[MAX_WAYS +: MAX_WAYS*RANK_W];
    end else begin
      cur_valid = '0;
      cur_ranks = '0;
    end
    cur_tags = row_sel[MAX_WAYS*(RANK_W+1) +: MAX_WAYS*KEY_BITS];
  end

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(wr_ctrl.flush)) |-> (row_valid == '0))
    else $error("rows still valid after a flush");

  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(wr_ctrl.write)) |-> row_valid[$past(wr_set)])
    else $error("written row not marked valid");

  a_bypass_src: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && byp_sel) |-> $past(wr_ctrl.write))
    else $error("forwarding selected without a write");

endmodule

`default_nettype wire

FILE: rtl/pwc_lru_update.sv
// Lookup, LRU promotion and fill with eviction for one set row.
`default_nettype none

module pwc_lru_update
  import pwc_pkg::*;
#(
  parameter int MAX_WAYS = MAX_WAYS_DEFAULT,
  parameter int KEY_BITS = KEY_BITS_DEFAULT,
  localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  wire logic                         active,
  input  wire func_t                        func,
  input  wire logic [KEY_BITS-1:0]          key,
  input  wire logic [CMP_W-1:0]             ways_eff,
  input  wire logic [MAX_WAYS-1:0]          cur_valid,
  input  wire logic [MAX_WAYS*RANK_W-1:0]   cur_ranks,
  input  wire logic [MAX_WAYS*KEY_BITS-1:0] cur_tags,
  output logic      [MAX_WAYS-1:0]          nxt_valid,
  output logic      [MAX_WAYS*RANK_W-1:0]   nxt_ranks,
  output logic      [MAX_WAYS*KEY_BITS-1:0] nxt_tags,
  output logic                              hit,
  output store_ctrl_t                       ctrl
);

  logic [RANK_W-1:0]          rank_w [MAX_WAYS];
  logic [RANK_W-1:0]          slid [MAX_WAYS];
  logic [MAX_WAYS-1:0]        match;
  logic                       any_match;
  logic [RANK_W-1:0]          match_rank;
  logic [MAX_WAYS-1:0]        keep;
  logic [MAX_WAYS-1:0]        free;
  logic [MAX_WAYS-1:0]        ins_onehot;
  logic [MAX_WAYS*RANK_W-1:0] prom_ranks;
  logic [MAX_WAYS*RANK_W-1:0] fill_ranks;
  logic [MAX_WAYS*KEY_BITS-1:0] fill_tags;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      rank_w[w] = cur_ranks[w*RANK_W +: RANK_W];
      match[w]  = cur_valid[w] && (cur_tags[w*KEY_BITS +: KEY_BITS] == key);
    end
    any_match  = |match;
    match_rank = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        match_rank = rank_w[w];
      end
    end
  end

  // Fill: drop the key if present, close its rank gap, keep only entries
  // ranked below ways-1, age them by one and put the key in the lowest
  // free way as most recently used.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      slid[w] = (any_match && (rank_w[w] > match_rank)) ? rank_w[w] - 1'b1 : rank_w[w];
      keep[w] = cur_valid[w] && !match[w] &&
                (CMP_W'(slid[w]) < (ways_eff - CMP_W'(1)));
    end
    free       = ~keep;
    ins_onehot = free & (~free + MAX_WAYS'(1));
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (ins_onehot[w]) begin
        fill_ranks[w*RANK_W +: RANK_W]     = '0;
        fill_tags[w*KEY_BITS +: KEY_BITS]  = key;
      end else begin
        fill_ranks[w*RANK_W +: RANK_W]     = keep[w] ? slid[w] + 1'b1 : '0;
        fill_tags[w*KEY_BITS +: KEY_BITS]  = cur_tags[w*KEY_BITS +: KEY_BITS];
      end
      if (match[w]) begin
        prom_ranks[w*RANK_W +: RANK_W] = '0;
      end else if (cur_valid[w] && (rank_w[w] < match_rank)) begin
        prom_ranks[w*RANK_W +: RANK_W] = rank_w[w] + 1'b1;
      end else begin
        prom_ranks[w*RANK_W +: RANK_W] = rank_w[w];
      end
    end
  end

  always_comb begin
    nxt_valid  = cur_valid;
    nxt_ranks  = cur_ranks;
    nxt_tags   = cur_tags;
    hit        = 1'b0;
    ctrl.write = 1'b0;
    ctrl.flush = 1'b0;
    case (func)
      FUNC_ACCESS: begin
        ctrl.write = active;
        if (any_match) begin
          hit       = active;
          nxt_ranks = prom_ranks;
        end else begin
          nxt_valid = keep | ins_onehot;
          nxt_ranks = fill_ranks;
          nxt_tags  = fill_tags;
        end
      end
      FUNC_FILL: begin
        ctrl.write = active;
        nxt_valid  = keep | ins_onehot;
        nxt_ranks  = fill_ranks;
        nxt_tags   = fill_tags;
      end
      FUNC_FLUSH: begin
        ctrl.flush = active;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/page_walk_cache_lru_tags.sv
// Top level of the page-walk cache tag store with true LRU order per set.
`default_nettype none

// Usage
// An item is presented on func, key and set_index together with start and is
// taken at a rising edge where start is high and busy is low. busy is held
// low, so an item can be issued in every cycle. Each item gives one result:
// done is high for exactly one cycle and hit is valid in that cycle. The
// receiver cannot stall; it must take the result when done is high.
// Results: an accepted item passes through the s1 stage registers and the done
// register, so results come in issue order, one item per cycle sustained.
// The set row is read from a memory at acceptance; the next cycle runs the
// compare, LRU update and fill on that row and writes it back. A following
// item to the same set takes the freshly written row through a forwarding
// register, so back-to-back items see each other's updates.
// The ways_in_use register is written on cfg_data when cfg_valid is high;
// cfg_ready is always high. Write it only while no item is in flight.
// Reset clears every set at once through per-row valid flags (no clearing
// pass) and sets ways_in_use to eight. A flush item does the same to the
// sets without touching the register.

module page_walk_cache_lru_tags
  import pwc_pkg::*;
#(
  parameter int SETS     = SETS_DEFAULT,
  parameter int MAX_WAYS = MAX_WAYS_DEFAULT,
  parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [KEY_IN_W-1:0] key,
  input  wire logic [SET_IN_W-1:0] set_index,
  output logic                     done,
  output logic                     hit,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SET_SPAN = 2 ** SET_IN_W;

  logic                         accept;
  logic [CFG_W-1:0]             ways_cfg;
  logic [CMP_W-1:0]             ways_eff;
  logic [KEY_BITS-1:0]          key_in;
  logic [SET_W-1:0]             set_lut [SET_SPAN];
  logic [SET_W-1:0]             set_in;

  logic                         s1_valid;
  func_t                        s1_func;
  logic [KEY_BITS-1:0]          s1_key;
  logic [SET_W-1:0]             s1_set;

  logic [MAX_WAYS-1:0]          cur_valid;
  logic [MAX_WAYS*RANK_W-1:0]   cur_ranks;
  logic [MAX_WAYS*KEY_BITS-1:0] cur_tags;
  logic [MAX_WAYS-1:0]          nxt_valid;
  logic [MAX_WAYS*RANK_W-1:0]   nxt_ranks;
  logic [MAX_WAYS*KEY_BITS-1:0] nxt_tags;
  logic                         upd_hit;
  store_ctrl_t                  upd_ctrl;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_cfg <= WAYS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ways_cfg <= cfg_data;
    end
  end

  // A zero setting acts as one way; anything above the array acts as all ways.
  always_comb begin
    if (ways_cfg == '0) begin
      ways_eff = CMP_W'(1);
    end else if (CMP_W'(ways_cfg) > CMP_W'(MAX_WAYS)) begin
      ways_eff = CMP_W'(MAX_WAYS);
    end else begin
      ways_eff = CMP_W'(ways_cfg);
    end
  end

  // The key is kept as its low KEY_BITS bits, or zero-extended when KEY_BITS is wider.
  if (KEY_BITS > KEY_IN_W) begin : g_key_wide
    assign key_in = {{(KEY_BITS - KEY_IN_W){1'b0}}, key};
  end else if (KEY_BITS == KEY_IN_W) begin : g_key_same
    assign key_in = key;
  end else begin : g_key_narrow
    assign key_in = key[KEY_BITS-1:0];
  end

  // The set index wraps modulo the set count; a small constant table does it.
  for (genvar g = 0; g < SET_SPAN; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % SETS);
  end
  assign set_in = set_lut[set_index];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= func_t'(func);
      s1_key  <= key_in;
      s1_set  <= set_in;
    end
  end

  pwc_row_store #(
    .SETS     (SETS),
    .MAX_WAYS (MAX_WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_set    (set_in),
    .wr_ctrl   (upd_ctrl),
    .wr_set    (s1_set),
    .wr_valid  (nxt_valid),
    .wr_ranks  (nxt_ranks),
    .wr_tags   (nxt_tags),
    .cur_valid (cur_valid),
    .cur_ranks (cur_ranks),
    .cur_tags  (cur_tags)
  );

  pwc_lru_update #(
    .MAX_WAYS (MAX_WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_update (
    .active    (s1_valid),
    .func      (s1_func),
    .key       (s1_key),
    .ways_eff  (ways_eff),
    .cur_valid (cur_valid),
    .cur_ranks (cur_ranks),
    .cur_tags  (cur_tags),
    .nxt_valid (nxt_valid),
    .nxt_ranks (nxt_ranks),
    .nxt_tags  (nxt_tags),
    .hit       (upd_hit),
    .ctrl      (upd_ctrl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= s1_valid;
      hit  <= upd_hit;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted item produced no result");

  a_hit_strobed: assert property (@(posedge clk) disable iff (rst)
    hit |-> done)
    else $error("hit raised without a result strobe");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (upd_ctrl.write && !upd_hit) |-> ($countones(nxt_valid) <= ways_eff))
    else $error("fill left more entries than ways in use");

  a_row_nonempty: assert property (@(posedge clk) disable iff (rst)
    upd_ctrl.write |-> (nxt_valid != '0))
    else $error("row written back with no valid entry");

endmodule

`default_nettype wire
